// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BMPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Next-cycle implication, disabled in reset.
`define BMPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ===== design/bmpd_pkg.sv =====
// Shared types and constants of the BMP stream decoder.
package bmpd_pkg;

   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned MAX_HEIGHT = 4096;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QAW    = $clog2(QDEPTH);

   localparam logic [1:0] KIND_INFO  = 2'd0;
   localparam logic [1:0] KIND_PAL   = 2'd1;
   localparam logic [1:0] KIND_PIXEL = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_SIG    = 3'd1;
   localparam logic [2:0] ERR_SHORT  = 3'd2;
   localparam logic [2:0] ERR_COMP   = 3'd3;
   localparam logic [2:0] ERR_DEPTH  = 3'd4;
   localparam logic [2:0] ERR_OFFSET = 3'd5;
   localparam logic [2:0] ERR_SIZE   = 3'd6;

   localparam logic [7:0] SIG_B = 8'h42;
   localparam logic [7:0] SIG_M = 8'h4D;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] column;
      logic [12:0] row;
      logic [31:0] value;
      logic        eoi;
      logic [2:0]  err;
   } result_type;

   // One queue entry: a full result plus an optional second 4-bit pixel
   typedef struct packed {
      result_type r0;
      logic       has1;
      logic [3:0] nib1;
      logic       eoi1;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// ===== design/bmpd_front.sv =====
// Byte parser: header, palette and pixel classification into queue entries.
module bmpd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           file_byte,
   input  logic                 first_byte,
   output logic                 push,
   output bmpd_pkg::entry_type  push_entry
);

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_HEADER   = 3'd1;
   localparam logic [2:0] PH_INFO     = 3'd2;
   localparam logic [2:0] PH_PALETTE  = 3'd3;
   localparam logic [2:0] PH_GAP      = 3'd4;
   localparam logic [2:0] PH_PIXELS   = 3'd5;
   localparam logic [2:0] PH_HALT     = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] fval_ff, fval_in;
   logic [31:0] dofs_ff, dofs_in;
   logic [32:0] hend_ff, hend_in;
   logic [33:0] pend_ff, pend_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] bpp_ff, bpp_in;
   logic [31:0] comp_ff, comp_in;
   logic [8:0]  pleft_ff, pleft_in;
   logic [14:0] rbc_ff, rbc_in;
   logic [14:0] roff_ff, roff_in;
   logic [12:0] frow_ff, frow_in;
   logic [23:0] pb_ff, pb_in;
   logic [12:0] j_ff, j_in;
   logic [1:0]  k_ff, k_in;

   function automatic logic [8:0] pal_count(input logic [15:0] bpp);
      if (bpp == 16'd8) return 9'd256;
      if (bpp == 16'd4) return 9'd16;
      return 9'd0;
   endfunction

   function automatic logic [2:0] next_phase(input logic [31:0] p, input logic [32:0] he,
                                             input logic [33:0] pe, input logic [31:0] dof);
      if ({1'b0, p} < he) return PH_INFO;
      if ({2'b0, p} < pe) return PH_PALETTE;
      if (p < dof) return PH_GAP;
      return PH_PIXELS;
   endfunction

   logic [2:0]  ph_c;
   logic [31:0] pos_c;
   logic [31:0] pos_nx;
   logic [5:0]  pos6;
   logic [1:0]  sh;
   logic [31:0] fv_new;
   logic [8:0]  pc;
   logic [33:0] pal_end;
   logic [12:0] w13, h13;
   logic [12:0] prow;
   logic [12:0] j4, j4p;
   logic [14:0] rb_raw;
   logic [14:0] o_nx;
   logic [1:0]  kp, kmax;
   logic [23:0] pb_new;
   logic        last;
   logic [13:0] frow_p1;

   always_comb begin
      ph_c   = first_byte ? PH_HEADER : phase_ff;
      pos_c  = first_byte ? 32'd0 : pos_ff;
      pos_nx = pos_c + 32'd1;
      pos6   = pos_c[5:0];
      if (pos6 >= 6'd26 && pos6 <= 6'd29) sh = {1'b0, pos6[0]};
      else sh = pos6[1:0] - 2'd2;
      fv_new  = ((sh == 2'd0) ? 32'd0 : fval_ff) | (32'(file_byte) << {sh, 3'b000});
      pc      = pal_count(bpp_ff);
      pal_end = {1'b0, hend_ff} + (34'(pc) << 2);
      w13     = width_ff[12:0];
      h13     = height_ff[12:0];
      prow    = h13 - 13'd1 - frow_ff;
      frow_p1 = {1'b0, frow_ff} + 14'd1;
      j4      = {roff_ff[11:0], 1'b0};
      j4p     = j4 + 13'd1;
      kp      = pos_c[1:0] - hend_ff[1:0];
      kmax    = (bpp_ff == 16'd32) ? 2'd3 : 2'd2;
      o_nx    = roff_ff + 15'd1;
      last    = 1'b0;
      unique case (bpp_ff)
         16'd32:  rb_raw = {width_ff[12:0], 2'b00};
         16'd24:  rb_raw = 15'(width_ff[12:0]) + {1'b0, width_ff[12:0], 1'b0};
         16'd8:   rb_raw = 15'(width_ff[12:0]);
         default: rb_raw = 15'((14'(width_ff[12:0]) + 14'd1) >> 1);
      endcase
      pb_new = pb_ff;

      phase_in  = phase_ff;
      pos_in    = pos_ff;
      fval_in   = fval_ff;
      dofs_in   = dofs_ff;
      hend_in   = hend_ff;
      pend_in   = pend_ff;
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      comp_in   = comp_ff;
      pleft_in  = pleft_ff;
      rbc_in    = rbc_ff;
      roff_in   = roff_ff;
      frow_in   = frow_ff;
      pb_in     = pb_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      push      = 1'b0;
      push_entry = '0;

      if (accept) begin
         unique case (ph_c)
            PH_HEADER: begin
               fval_in  = fv_new;
               pos_in   = pos_nx;
               phase_in = PH_HEADER;
               unique case (pos6)
                  6'd0: begin
                     if (file_byte != bmpd_pkg::SIG_B) push = 1'b1;
                  end
                  6'd1: begin
                     if (file_byte != bmpd_pkg::SIG_M) push = 1'b1;
                  end
                  6'd13: dofs_in = fv_new;
                  6'd17: begin
                     hend_in = 33'(fv_new) + 33'd14;
                     if (fv_new < 32'd24) begin
                        push = 1'b1;
                        push_entry.r0.err = bmpd_pkg::ERR_SHORT;
                     end
                  end
                  6'd21: width_in  = fv_new;
                  6'd25: height_in = fv_new;
                  6'd29: bpp_in    = fv_new[15:0];
                  6'd33: comp_in   = fv_new;
                  6'd37: begin
                     push = 1'b1;
                     if (comp_ff != 32'd0) push_entry.r0.err = bmpd_pkg::ERR_COMP;
                     else if (bpp_ff != 16'd32 && bpp_ff != 16'd24 && bpp_ff != 16'd8 &&
                              bpp_ff != 16'd4)
                        push_entry.r0.err = bmpd_pkg::ERR_DEPTH;
                     else if (width_ff > 32'(bmpd_pkg::MAX_WIDTH) ||
                              height_ff > 32'(bmpd_pkg::MAX_HEIGHT))
                        push_entry.r0.err = bmpd_pkg::ERR_SIZE;
                     else if (pal_end > {2'b0, dofs_ff})
                        push_entry.r0.err = bmpd_pkg::ERR_OFFSET;
                     else begin
                        push_entry.r0.kind   = bmpd_pkg::KIND_INFO;
                        push_entry.r0.column = w13;
                        push_entry.r0.row    = h13;
                        push_entry.r0.value  = (bpp_ff >= 16'd24) ? 32'd24 : 32'd8;
                        rbc_in   = (rb_raw + 15'd3) & ~15'd3;
                        pleft_in = pc;
                        pend_in  = pal_end;
                        pos_in   = 32'd38;
                        roff_in  = '0;
                        frow_in  = '0;
                        j_in     = '0;
                        k_in     = '0;
                        if (w13 == 13'd0 || h13 == 13'd0) phase_in = PH_HALT;
                        else phase_in = next_phase(32'd38, hend_ff, pal_end, dofs_ff);
                     end
                  end
                  default: ;
               endcase
               if (pos6 <= 6'd1 && push) push_entry.r0.err = bmpd_pkg::ERR_SIG;
               if (push && push_entry.r0.err != bmpd_pkg::ERR_NONE) begin
                  push_entry.r0.kind = bmpd_pkg::KIND_ERROR;
                  phase_in = PH_HALT;
               end
            end
            PH_INFO, PH_GAP: begin
               pos_in   = pos_nx;
               phase_in = next_phase(pos_nx, hend_ff, pend_ff, dofs_ff);
            end
            PH_PALETTE: begin
               case (kp)
                  2'd0: pb_in = {16'd0, file_byte};
                  2'd1: pb_in = pb_ff | {8'd0, file_byte, 8'd0};
                  2'd2: pb_in = pb_ff | {file_byte, 16'd0};
                  default: begin
                     push = 1'b1;
                     push_entry.r0.kind   = bmpd_pkg::KIND_PAL;
                     push_entry.r0.column = 13'(pc - pleft_ff);
                     push_entry.r0.value  = {file_byte, pb_ff};
                     if (pleft_ff != 9'd0) pleft_in = pleft_ff - 9'd1;
                  end
               endcase
               pos_in   = pos_nx;
               phase_in = next_phase(pos_nx, hend_ff, pend_ff, dofs_ff);
            end
            PH_PIXELS: begin
               push_entry.r0.kind = bmpd_pkg::KIND_PIXEL;
               push_entry.r0.row  = prow;
               if (bpp_ff == 16'd4) begin
                  push_entry.r0.column = j4;
                  push_entry.r0.value  = {28'd0, file_byte[7:4]};
                  push_entry.r0.eoi    = (j4p == w13) && (frow_p1 == {1'b0, h13});
                  push = (j4 < w13);
                  push_entry.has1 = (j4p < w13);
                  push_entry.nib1 = file_byte[3:0];
                  push_entry.eoi1 = ({1'b0, j4p} + 14'd1 == {1'b0, w13}) &&
                                    (frow_p1 == {1'b0, h13});
                  last = (push && push_entry.r0.eoi) ||
                         (push_entry.has1 && push_entry.eoi1);
               end else if (bpp_ff == 16'd8) begin
                  push_entry.r0.column = roff_ff[12:0];
                  push_entry.r0.value  = {24'd0, file_byte};
                  push_entry.r0.eoi    = (o_nx == 15'(w13)) && (frow_p1 == {1'b0, h13});
                  push = (roff_ff < 15'(w13));
                  last = push && push_entry.r0.eoi;
               end else begin
                  if (j_ff < w13 && k_ff != 2'd3) begin
                     case (k_ff)
                        2'd0:    pb_new = {16'd0, file_byte};
                        2'd1:    pb_new = pb_ff | {8'd0, file_byte, 8'd0};
                        default: pb_new = pb_ff | {file_byte, 16'd0};
                     endcase
                     pb_in = pb_new;
                     push  = (k_ff == 2'd2);
                  end
                  push_entry.r0.column = j_ff;
                  push_entry.r0.value  = {8'd0, pb_new};
                  push_entry.r0.eoi    = ({1'b0, j_ff} + 14'd1 == {1'b0, w13}) &&
                                         (frow_p1 == {1'b0, h13});
                  last = push && push_entry.r0.eoi;
                  if (k_ff == kmax) begin
                     k_in = 2'd0;
                     j_in = j_ff + 13'd1;
                  end else begin
                     k_in = k_ff + 2'd1;
                  end
               end
               if (o_nx >= rbc_ff) begin
                  roff_in = '0;
                  frow_in = frow_ff + 13'd1;
                  j_in    = '0;
                  k_in    = '0;
               end else begin
                  roff_in = o_nx;
               end
               pos_in = pos_nx;
               if (last) phase_in = PH_HALT;
            end
            default: phase_in = ph_c;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
      fval_ff   <= fval_in;
      dofs_ff   <= dofs_in;
      hend_ff   <= hend_in;
      pend_ff   <= pend_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      bpp_ff    <= bpp_in;
      comp_ff   <= comp_in;
      pleft_ff  <= pleft_in;
      rbc_ff    <= rbc_in;
      roff_ff   <= roff_in;
      frow_ff   <= frow_in;
      pb_ff     <= pb_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
   end

endmodule

// ===== design/bmpd_queue.sv =====
// Short entry queue between the parser and the output stage.
module bmpd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bmpd_pkg::entry_type  push_entry,
   input  logic                 pop,
   output bmpd_pkg::entry_type  head,
   output bmpd_pkg::qstat_type  stat
);

   bmpd_pkg::entry_type mem_ff [bmpd_pkg::QDEPTH];
   logic [bmpd_pkg::QAW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [bmpd_pkg::QAW:0]   cnt_ff, cnt_in;
   logic                     do_pop;

   always_comb begin
      do_pop = pop && (cnt_ff != '0);
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
      head   = mem_ff[rd_ff];
      stat.empty = (cnt_ff == '0);
      stat.full  = (cnt_ff == (bmpd_pkg::QAW+1)'(bmpd_pkg::QDEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_entry;
   end

endmodule

// ===== design/bmpd_back.sv =====
// Output stage: unpack queue entries into one result per transaction.
module bmpd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bmpd_pkg::entry_type  head,
   input  bmpd_pkg::qstat_type  stat,
   output logic                 pop,
   input  logic                 out_ready,
   output logic                 out_valid,
   output bmpd_pkg::result_type out_res
);

   logic                 valid_ff, valid_in;
   logic                 half_ff, half_in;
   bmpd_pkg::result_type res_ff, res_in;
   bmpd_pkg::result_type second;
   logic                 load;

   always_comb begin
      second        = head.r0;
      second.column = head.r0.column + 13'd1;
      second.value  = {28'd0, head.nib1};
      second.eoi    = head.eoi1;
      load     = !stat.empty && (!valid_ff || out_ready);
      valid_in = valid_ff;
      half_in  = half_ff;
      res_in   = res_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (!half_ff) begin
            res_in = head.r0;
            if (head.has1) half_in = 1'b1;
            else pop = 1'b1;
         end else begin
            res_in  = second;
            half_in = 1'b0;
            pop     = 1'b1;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
      res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

// ===== design/bmp_raster_stream_decoder.sv =====
// A result passes two registers: the queue entry, written at the edge that accepts its
// byte, then the output register, loaded from the queue head when empty or drained.
// Throughput: one file byte per cycle while the four-entry queue has room; a 4-bit byte
// giving two pixels yields two results, so a long 4-bit run fills the queue and is then
// held to the output rate, at most one result per cycle, set by the output register.
// Reset (synchronous, active high) idles the parser and empties queue and output.
module bmp_raster_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_file_byte,
   input  logic        req_first_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [12:0] rsp_column,
   output logic [12:0] rsp_row,
   output logic [31:0] rsp_value,
   output logic        rsp_end_of_image,
   output logic [2:0]  rsp_error_code
);

   logic                 accept;
   logic                 push, pop;
   bmpd_pkg::entry_type  push_entry, head;
   bmpd_pkg::qstat_type  stat;
   bmpd_pkg::result_type res;

   // Take a byte whenever the queue has room; a transaction yields at most one entry
   assign req_ready = !stat.full;
   assign accept    = req_valid && req_ready;

   // Front: parse header, palette and pixel bytes
   bmpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .file_byte  (req_file_byte),
      .first_byte (req_first_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decouple parser from the result channel
   bmpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (stat)
   );

   // Back: hand out results, splitting paired 4-bit pixels
   bmpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .stat      (stat),
      .pop       (pop),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_res   (res)
   );

   assign rsp_kind         = res.kind;
   assign rsp_column       = res.column;
   assign rsp_row          = res.row;
   assign rsp_value        = res.value;
   assign rsp_end_of_image = res.eoi;
   assign rsp_error_code   = res.err;

endmodule

// ===== design/bmpd_checker.sv =====
// Port-level checks on the decoder result channel, bound to the top level.
`include "assert_macros.svh"

module bmpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [12:0] rsp_column,
   input logic [12:0] rsp_row,
   input logic [31:0] rsp_value,
   input logic        rsp_end_of_image,
   input logic [2:0]  rsp_error_code
);

   `BMPD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_value) && $stable(rsp_kind))
   `BMPD_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_kind == bmpd_pkg::KIND_ERROR,
      rsp_column == 13'd0 && rsp_row == 13'd0 && rsp_value == 32'd0 &&
      rsp_error_code != bmpd_pkg::ERR_NONE)
   `BMPD_ASSERT_NOW(a_code_only_err, clock, reset,
      rsp_valid && rsp_kind != bmpd_pkg::KIND_ERROR, rsp_error_code == bmpd_pkg::ERR_NONE)
   `BMPD_ASSERT_NOW(a_eoi_pixel, clock, reset, rsp_valid && rsp_end_of_image,
      rsp_kind == bmpd_pkg::KIND_PIXEL)

endmodule

bind bmp_raster_stream_decoder bmpd_checker u_chk (.*);
